@@ rtl/core/bset_pkg.sv @@
// Shared types and constants for the bucketed sorted edit table.
// No dependencies; used by the controller, the datapath and the top level.
package bset_pkg;

	// Request operation codes
	typedef enum logic [1:0] {
		OP_SET    = 2'd0,
		OP_PROBE  = 2'd1,
		OP_REPLAY = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	// Frames the pool-full message stays up
	localparam logic [6:0] MSG_FRAMES = 7'd90;

	typedef struct packed {
		op_t          op;
		logic [15:0]  pos_x;
		logic [15:0]  pos_y;
		logic [15:0]  pos_z;
		logic [7:0]   new_block;
		logic         new_valid;
		logic [7:0]   current_block;
		logic         column_ready;
		logic         column_resident;
		logic [9:0]   entry_index;
	} in_t;

	typedef struct packed {
		logic         accepted;
		logic         write_cell;
		logic [7:0]   rec_x;
		logic [6:0]   rec_y;
		logic [7:0]   rec_z;
		logic [7:0]   rec_block;
		logic         rec_valid;
		logic         rec_last;
		logic         message_active;
		logic [31:0]  overflow_count;
		logic [10:0]  edit_count;
	} out_t;

	// Controller states
	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_DEC, ST_RDLO, ST_RDHI, ST_HIW, ST_REP, ST_REPW,
		ST_SRCH, ST_SCMP, ST_ACT, ST_RMRD, ST_RMWR, ST_INRD, ST_INWR,
		ST_BSRD, ST_BSWR, ST_FIN
	} state_t;

	// Datapath commands
	typedef enum logic [4:0] {
		CMD_NONE, CMD_CLR, CMD_LOAD, CMD_DEC, CMD_RDLO, CMD_RDHI, CMD_HIW,
		CMD_REP, CMD_REPW, CMD_SRCH, CMD_SCMP, CMD_ACT, CMD_RMRD, CMD_RMWR,
		CMD_INRD, CMD_INWR, CMD_BSRD, CMD_BSWR, CMD_FIN
	} cmd_t;

	// What a set or probe does after the search
	typedef enum logic [1:0] {
		ACT_DONE,
		ACT_REMOVE,
		ACT_INSERT
	} act_t;

	typedef struct packed {
		cmd_t cmd;
	} ctl_t;

	typedef struct packed {
		logic clr_last;
		logic go;
		logic is_rep;
		logic srch_more;
		logic key_eq;
		act_t act;
		logic rm_more;
		logic in_more;
		logic bs_more;
	} sts_t;

endpackage

@@ rtl/core/bset_ctrl.sv @@
// Controller state machine for the bucketed sorted edit table.
// Depends on bset_pkg; drives commands to bset_dpath and reads its status.
module bset_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  bset_pkg::sts_t  sts,
	output bset_pkg::ctl_t  ctl,
	output logic            busy
);
	import bset_pkg::*;

	state_t state_q, state_d;

	// State register; reset starts the bucket table clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR:  if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE: if (start) state_d = ST_DEC;
			ST_DEC:  state_d = sts.go ? ST_RDLO : ST_FIN;
			ST_RDLO: state_d = ST_RDHI;
			ST_RDHI: state_d = ST_HIW;
			ST_HIW:  state_d = sts.is_rep ? ST_REP : ST_SRCH;
			ST_REP:  state_d = ST_REPW;
			ST_REPW: state_d = ST_FIN;
			ST_SRCH: state_d = sts.srch_more ? ST_SCMP : ST_ACT;
			ST_SCMP: state_d = sts.key_eq ? ST_ACT : ST_SRCH;
			ST_ACT: begin
				case (sts.act)
					ACT_REMOVE: state_d = ST_RMRD;
					ACT_INSERT: state_d = ST_INRD;
					default:    state_d = ST_FIN;
				endcase
			end
			ST_RMRD: state_d = sts.rm_more ? ST_RMWR : ST_BSRD;
			ST_RMWR: state_d = ST_RMRD;
			ST_INRD: state_d = sts.in_more ? ST_INWR : ST_BSRD;
			ST_INWR: state_d = ST_INRD;
			ST_BSRD: state_d = sts.bs_more ? ST_BSWR : ST_FIN;
			ST_BSWR: state_d = ST_BSRD;
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		busy    = (state_q != ST_IDLE);
		ctl.cmd = CMD_NONE;
		case (state_q)
			ST_CLR:  ctl.cmd = CMD_CLR;
			ST_IDLE: ctl.cmd = start ? CMD_LOAD : CMD_NONE;
			ST_DEC:  ctl.cmd = CMD_DEC;
			ST_RDLO: ctl.cmd = CMD_RDLO;
			ST_RDHI: ctl.cmd = CMD_RDHI;
			ST_HIW:  ctl.cmd = CMD_HIW;
			ST_REP:  ctl.cmd = CMD_REP;
			ST_REPW: ctl.cmd = CMD_REPW;
			ST_SRCH: ctl.cmd = CMD_SRCH;
			ST_SCMP: ctl.cmd = CMD_SCMP;
			ST_ACT:  ctl.cmd = CMD_ACT;
			ST_RMRD: ctl.cmd = CMD_RMRD;
			ST_RMWR: ctl.cmd = CMD_RMWR;
			ST_INRD: ctl.cmd = CMD_INRD;
			ST_INWR: ctl.cmd = CMD_INWR;
			ST_BSRD: ctl.cmd = CMD_BSRD;
			ST_BSWR: ctl.cmd = CMD_BSWR;
			ST_FIN:  ctl.cmd = CMD_FIN;
			default: ctl.cmd = CMD_NONE;
		endcase
	end

endmodule

@@ rtl/core/bset_dpath.sv @@
// Datapath: record memory, bucket start memory, counters and result register.
// Depends on bset_pkg; sequenced by bset_ctrl.
module bset_dpath #(
	parameter int MAX_EDITS  = 1024,
	parameter int WORLD_X    = 256,
	parameter int WORLD_Y    = 128,
	parameter int WORLD_Z    = 256,
	parameter int CELL_SHIFT = 4,
	parameter int BUCKETS    = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bset_pkg::ctl_t  ctl,
	input  bset_pkg::in_t   req,
	output bset_pkg::sts_t  sts,
	output bset_pkg::out_t  rsp,
	output logic            done
);
	import bset_pkg::*;

	localparam int AW     = $clog2(MAX_EDITS);
	localparam int CW     = $clog2(MAX_EDITS + 1);
	localparam int BA     = $clog2(BUCKETS + 1);
	localparam int BP     = $clog2(BUCKETS + 2);
	localparam int XW     = $clog2(WORLD_X);
	localparam int YW     = $clog2(WORLD_Y);
	localparam int ZW     = $clog2(WORLD_Z);
	localparam int KW     = XW + YW + ZW;
	localparam int RW     = KW + 16;
	localparam int COLS_X = WORLD_X >> CELL_SHIFT;
	localparam int COLS_Z = WORLD_Z >> CELL_SHIFT;
	localparam int BKW    = 30;
	localparam int IXW    = CW + 11;

	// Memories
	logic [RW-1:0] rec_mem [MAX_EDITS];
	logic [CW-1:0] bs_mem  [BUCKETS + 1];

	logic [RW-1:0] rec_rd_q;
	logic [CW-1:0] bs_rd_q;

	in_t           in_q;
	logic [BA-1:0] b_q;
	logic [CW-1:0] lo_q, hi_q, mid_q, at_q, ptr_q, count_q;
	logic [BP-1:0] bptr_q;
	logic          dec_q, found_q;
	logic [7:0]    orig_q;
	logic [IXW-1:0] idx_q;
	logic          hit_q;
	logic [31:0]   ovf_q;
	logic [6:0]    msg_q;
	logic          acc_q, wr_q, rv_q, rl_q;
	logic [7:0]    rx_q, rz_q, rb_q;
	logic [6:0]    ry_q;
	out_t          rsp_q;
	logic          done_q;

	// Request decode
	logic            set_probe, y_ok, ok, x_in, z_in, xc_in, zc_in;
	logic [BKW-1:0]  bc, br;
	logic            go_sp, go_rp, full;
	logic [KW-1:0]   key_in, key_mem;
	logic [CW-1:0]   mid;
	logic [IXW-1:0]  idx;

	always_comb begin
		set_probe = (in_q.op == OP_SET) || (in_q.op == OP_PROBE);
		y_ok  = {1'b0, in_q.pos_y} < 17'(WORLD_Y);
		ok    = ((in_q.op == OP_PROBE) || in_q.new_valid) && in_q.column_ready && y_ok;
		x_in  = {1'b0, in_q.pos_x} < 17'(WORLD_X);
		z_in  = {1'b0, in_q.pos_z} < 17'(WORLD_Z);
		xc_in = {1'b0, in_q.pos_x} < 17'(COLS_X);
		zc_in = {1'b0, in_q.pos_z} < 17'(COLS_Z);
		bc    = BKW'(in_q.pos_x >> CELL_SHIFT) * BKW'(COLS_Z)
		      + BKW'(in_q.pos_z >> CELL_SHIFT);
		br    = BKW'(in_q.pos_x) * BKW'(COLS_Z) + BKW'(in_q.pos_z);
		go_sp = ok && x_in && z_in && (bc < BKW'(BUCKETS));
		go_rp = (count_q != '0) && in_q.column_resident && xc_in && zc_in
		      && (br < BKW'(BUCKETS));
		full  = count_q >= CW'(MAX_EDITS);
		key_in  = {in_q.pos_x[XW-1:0], in_q.pos_y[YW-1:0], in_q.pos_z[ZW-1:0]};
		key_mem = rec_rd_q[RW-1:16];
		mid   = lo_q + ((hi_q - lo_q) >> 1);
		idx   = IXW'(lo_q) + IXW'(in_q.entry_index);
	end

	// Status to the controller
	always_comb begin
		sts.clr_last  = (bptr_q == BP'(BUCKETS));
		sts.go        = set_probe ? go_sp : ((in_q.op == OP_REPLAY) && go_rp);
		sts.is_rep    = (in_q.op == OP_REPLAY);
		sts.srch_more = lo_q < hi_q;
		sts.key_eq    = (key_mem == key_in);
		sts.rm_more   = (CW + 1)'(ptr_q) + 1'b1 < (CW + 1)'(count_q);
		sts.in_more   = ptr_q > at_q;
		sts.bs_more   = bptr_q <= BP'(BUCKETS);
		sts.act       = ACT_DONE;
		if (in_q.op == OP_SET) begin
			if (found_q) begin
				if (in_q.new_block == orig_q) sts.act = ACT_REMOVE;
			end else if ((in_q.new_block != in_q.current_block) && !full) begin
				sts.act = ACT_INSERT;
			end
		end
	end

	// Memory port control
	logic          rec_re, rec_we, bs_re, bs_we;
	logic [AW-1:0] rec_ra, rec_wa;
	logic [RW-1:0] rec_wd;
	logic [BA-1:0] bs_ra, bs_wa;
	logic [CW-1:0] bs_wd;

	always_comb begin
		rec_re = 1'b0;
		rec_ra = AW'(mid);
		rec_we = 1'b0;
		rec_wa = AW'(ptr_q);
		rec_wd = rec_rd_q;
		bs_re  = 1'b0;
		bs_ra  = BA'(bptr_q);
		bs_we  = 1'b0;
		bs_wa  = BA'(bptr_q);
		bs_wd  = dec_q ? bs_rd_q - 1'b1 : bs_rd_q + 1'b1;
		case (ctl.cmd)
			CMD_CLR: begin
				bs_we = 1'b1;
				bs_wd = '0;
			end
			CMD_RDLO: begin
				bs_re = 1'b1;
				bs_ra = b_q;
			end
			CMD_RDHI: begin
				bs_re = 1'b1;
				bs_ra = b_q + 1'b1;
			end
			CMD_REP: begin
				rec_re = 1'b1;
				rec_ra = AW'(idx);
			end
			CMD_SRCH: rec_re = sts.srch_more;
			CMD_ACT: begin
				rec_wa = AW'(at_q);
				rec_wd = {rec_rd_q[RW-1:8], in_q.new_block};
				rec_we = (in_q.op == OP_SET) && found_q && (sts.act == ACT_DONE);
			end
			CMD_RMRD: begin
				rec_re = sts.rm_more;
				rec_ra = AW'(ptr_q + 1'b1);
			end
			CMD_RMWR: rec_we = 1'b1;
			CMD_INRD: begin
				rec_re = sts.in_more;
				rec_ra = AW'(ptr_q - 1'b1);
				rec_we = !sts.in_more;
				rec_wa = AW'(at_q);
				rec_wd = {key_in, in_q.current_block, in_q.new_block};
			end
			CMD_INWR: rec_we = 1'b1;
			CMD_BSRD: bs_re = sts.bs_more;
			CMD_BSWR: bs_we = 1'b1;
			default: ;
		endcase
	end

	// Record memory
	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_wa] <= rec_wd;
		end
		if (rec_re) begin
			rec_rd_q <= rec_mem[rec_ra];
		end
	end

	// Bucket start memory
	always_ff @(posedge clk) begin
		if (bs_we) begin
			bs_mem[bs_wa] <= bs_wd;
		end
		if (bs_re) begin
			bs_rd_q <= bs_mem[bs_ra];
		end
	end

	// Control state: counters, sweep pointer, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= '0;
			msg_q   <= '0;
			bptr_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (ctl.cmd == CMD_FIN);
			case (ctl.cmd)
				CMD_CLR:  bptr_q <= bptr_q + 1'b1;
				CMD_DEC: begin
					if ((in_q.op == OP_TICK) && (msg_q != '0)) msg_q <= msg_q - 1'b1;
				end
				CMD_ACT: begin
					if (set_probe && !found_q && full &&
					    ((in_q.op == OP_PROBE) || (in_q.new_block != in_q.current_block))) begin
						ovf_q <= ovf_q + 1'b1;
						msg_q <= MSG_FRAMES;
					end
				end
				CMD_RMRD: begin
					if (!sts.rm_more) begin
						count_q <= count_q - 1'b1;
						bptr_q  <= BP'(b_q) + 1'b1;
					end
				end
				CMD_INRD: begin
					if (!sts.in_more) begin
						count_q <= count_q + 1'b1;
						bptr_q  <= BP'(b_q) + 1'b1;
					end
				end
				CMD_BSWR: bptr_q <= bptr_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Payload registers for the request in flight
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_LOAD: in_q <= req;
			CMD_DEC: begin
				b_q     <= set_probe ? BA'(bc) : BA'(br);
				found_q <= 1'b0;
				acc_q   <= set_probe && ok && !go_sp;
				wr_q    <= (in_q.op == OP_SET) && ok && !go_sp;
				rv_q    <= 1'b0;
				rl_q    <= 1'b0;
				rx_q    <= '0;
				ry_q    <= '0;
				rz_q    <= '0;
				rb_q    <= '0;
			end
			CMD_RDHI: lo_q <= bs_rd_q;
			CMD_HIW:  hi_q <= (bs_rd_q > count_q) ? count_q : bs_rd_q;
			CMD_REP: begin
				idx_q <= idx;
				hit_q <= idx < IXW'(hi_q);
			end
			CMD_REPW: begin
				if (hit_q) begin
					rv_q <= 1'b1;
					wr_q <= 1'b1;
					rl_q <= (idx_q + 1'b1) == IXW'(hi_q);
					rx_q <= 8'(16'(rec_rd_q[RW-1 -: XW]));
					ry_q <= 7'(16'(rec_rd_q[RW-XW-1 -: YW]));
					rz_q <= 8'(16'(rec_rd_q[RW-XW-YW-1 -: ZW]));
					rb_q <= rec_rd_q[7:0];
				end
			end
			CMD_SRCH: begin
				mid_q <= mid;
				if (!sts.srch_more) at_q <= lo_q;
			end
			CMD_SCMP: begin
				if (sts.key_eq) begin
					found_q <= 1'b1;
					at_q    <= mid_q;
					orig_q  <= rec_rd_q[15:8];
				end else if (key_mem < key_in) begin
					lo_q <= mid_q + 1'b1;
				end else begin
					hi_q <= mid_q;
				end
			end
			CMD_ACT: begin
				if (in_q.op == OP_PROBE) begin
					acc_q <= found_q || !full;
				end else if (found_q || (in_q.new_block == in_q.current_block) || !full) begin
					acc_q <= 1'b1;
					wr_q  <= 1'b1;
				end
				ptr_q <= (sts.act == ACT_REMOVE) ? at_q : count_q;
				dec_q <= (sts.act == ACT_REMOVE);
			end
			CMD_RMWR: ptr_q <= ptr_q + 1'b1;
			CMD_INWR: ptr_q <= ptr_q - 1'b1;
			CMD_FIN: begin
				rsp_q.accepted       <= acc_q;
				rsp_q.write_cell     <= wr_q;
				rsp_q.rec_x          <= rx_q;
				rsp_q.rec_y          <= ry_q;
				rsp_q.rec_z          <= rz_q;
				rsp_q.rec_block      <= rb_q;
				rsp_q.rec_valid      <= rv_q;
				rsp_q.rec_last       <= rl_q;
				rsp_q.message_active <= (msg_q != '0);
				rsp_q.overflow_count <= ovf_q;
				rsp_q.edit_count     <= 11'(count_q);
			end
			default: ;
		endcase
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

@@ rtl/core/bucketed_sorted_edit_table.sv @@
// Top level of the bucketed sorted edit table.
// Depends on bset_pkg, bset_ctrl and bset_dpath.
//
// A request is taken when start is high and busy is low; its result shows on
// rsp for one cycle with done high and cannot be held off. After reset the
// block clears all BUCKETS+1 entries of its bucket start table with busy high.
// Ticks, refused requests and cells outside the world go from decode straight
// to the finish; a replay reads the bucket bounds and then one record. A set
// or probe reads the bucket bounds and then runs a binary search, one record
// probe at a time through the single record memory read port. An insert or
// removal then moves every record above the edit point, one at a time, and
// walks the bucket start table entries above the bucket.
module bucketed_sorted_edit_table #(
	parameter int MAX_EDITS  = 1024,
	parameter int WORLD_X    = 256,
	parameter int WORLD_Y    = 128,
	parameter int WORLD_Z    = 256,
	parameter int CELL_SHIFT = 4,
	parameter int BUCKETS    = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  bset_pkg::in_t   req,
	output logic            busy,
	output logic            done,
	output bset_pkg::out_t  rsp
);
	import bset_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// Sequencer
	bset_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	// Storage and arithmetic
	bset_dpath #(
		.MAX_EDITS  (MAX_EDITS),
		.WORLD_X    (WORLD_X),
		.WORLD_Y    (WORLD_Y),
		.WORLD_Z    (WORLD_Z),
		.CELL_SHIFT (CELL_SHIFT),
		.BUCKETS    (BUCKETS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.sts    (sts),
		.rsp    (rsp),
		.done   (done)
	);

endmodule

@@ dv/bucketed_sorted_edit_table_chk.sv @@
// Checker for the bucketed sorted edit table: watches requests and responses,
// keeps a shadow pool and compares each response. Depends on bset_pkg.
module bucketed_sorted_edit_table_chk #(
	parameter int MAX_EDITS  = 1024,
	parameter int WORLD_X    = 256,
	parameter int WORLD_Y    = 128,
	parameter int WORLD_Z    = 256,
	parameter int CELL_SHIFT = 4,
	parameter int BUCKETS    = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  bset_pkg::in_t   req,
	input  logic            done,
	input  bset_pkg::out_t  rsp,
	output int              fail_count,
	output int              pending
);
	import bset_pkg::*;

	localparam int COLS_X = WORLD_X >> CELL_SHIFT;
	localparam int COLS_Z = WORLD_Z >> CELL_SHIFT;

	typedef struct {
		int unsigned cx, cy, cz;
		logic [7:0]  orig, blk;
	} edit_t;

	edit_t       pool[MAX_EDITS];
	int unsigned bstart[BUCKETS+1];
	int unsigned nrec;
	logic [31:0] ovf;
	int unsigned frames;
	out_t        rsp_q[$];

	function automatic longint unsigned cell_key(int unsigned x, y, z);
		return (longint'(x) * WORLD_Y + y) * WORLD_Z + z;
	endfunction

	// Compare one field; returns 1 on mismatch
	function automatic bit chk(string name, logic [31:0] ev, logic [31:0] av);
		if (av !== ev) begin
			$error("%s: expected %0h, actual %0h", name, ev, av);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the shadow pool by one request and return its expected response
	function automatic out_t predict_rsp(in_t r);
		out_t o;
		int x, y, z;
		int unsigned b, lo, hi, mid, at, idx, stop;
		bit ok, inext, found;
		longint unsigned k, mk;
		o = '0;
		x = int'($signed(r.pos_x));
		y = int'($signed(r.pos_y));
		z = int'($signed(r.pos_z));
		if (r.op == OP_SET || r.op == OP_PROBE) begin
			ok = (r.op == OP_PROBE || r.new_valid) && r.column_ready
				&& y >= 0 && y < WORLD_Y;
			if (ok) begin
				inext = x >= 0 && x < WORLD_X && z >= 0 && z < WORLD_Z;
				b = 0;
				if (inext) begin
					b = (x >> CELL_SHIFT) * COLS_Z + (z >> CELL_SHIFT);
					if (b >= BUCKETS) inext = 0;
				end
				if (!inext) begin
					o.accepted = 1;
				end else begin
					// binary search within the bucket
					k = cell_key(x, y, z);
					lo = bstart[b];
					hi = bstart[b+1];
					if (hi > nrec) hi = nrec;
					found = 0;
					while (lo < hi && !found) begin
						mid = lo + ((hi - lo) >> 1);
						mk = cell_key(pool[mid].cx, pool[mid].cy, pool[mid].cz);
						if (mk == k) begin
							found = 1;
							lo = mid;
						end else if (mk < k) lo = mid + 1;
						else hi = mid;
					end
					at = lo;
					if (r.op == OP_PROBE) begin
						if (found || nrec < MAX_EDITS) o.accepted = 1;
						else begin
							ovf++;
							frames = 32'(MSG_FRAMES);
						end
					end else if (found) begin
						if (r.new_block == pool[at].orig) begin
							for (int i = at; i + 1 < nrec; i++) pool[i] = pool[i+1];
							nrec--;
							for (int i = b + 1; i <= BUCKETS; i++) bstart[i]--;
						end else pool[at].blk = r.new_block;
						o.accepted = 1;
					end else if (r.new_block == r.current_block) begin
						o.accepted = 1;
					end else if (nrec >= MAX_EDITS) begin
						ovf++;
						frames = 32'(MSG_FRAMES);
					end else begin
						for (int i = nrec; i > at; i--) pool[i] = pool[i-1];
						pool[at] = '{x, y, z, r.current_block, r.new_block};
						nrec++;
						for (int i = b + 1; i <= BUCKETS; i++) bstart[i]++;
						o.accepted = 1;
					end
				end
			end
			if (r.op == OP_SET) o.write_cell = o.accepted;
		end else if (r.op == OP_REPLAY) begin
			if (nrec != 0 && r.column_resident && x >= 0 && x < COLS_X
					&& z >= 0 && z < COLS_Z) begin
				b = x * COLS_Z + z;
				if (b < BUCKETS) begin
					stop = bstart[b+1];
					if (stop > nrec) stop = nrec;
					idx = bstart[b] + 32'(r.entry_index);
					if (idx < stop) begin
						o.rec_valid = 1;
						o.write_cell = 1;
						o.rec_last = (idx + 1 == stop);
						o.rec_x = pool[idx].cx[7:0];
						o.rec_y = pool[idx].cy[6:0];
						o.rec_z = pool[idx].cz[7:0];
						o.rec_block = pool[idx].blk;
					end
				end
			end
		end else if (frames > 0) frames--;
		o.message_active = frames != 0;
		o.overflow_count = ovf;
		o.edit_count = nrec[10:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t e;
		bit bad;
		if (!arst_n) begin
			foreach (bstart[i]) bstart[i] = 0;
			nrec = 0;
			ovf = 0;
			frames = 0;
			rsp_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			bad = 0;
			if (done) begin
				if (rsp_q.size() == 0) begin
					$error("response with no request outstanding");
					bad = 1;
				end else begin
					e = rsp_q.pop_front();
					bad |= chk("accepted", 32'(e.accepted), 32'(rsp.accepted));
					bad |= chk("write_cell", 32'(e.write_cell), 32'(rsp.write_cell));
					bad |= chk("rec_x", 32'(e.rec_x), 32'(rsp.rec_x));
					bad |= chk("rec_y", 32'(e.rec_y), 32'(rsp.rec_y));
					bad |= chk("rec_z", 32'(e.rec_z), 32'(rsp.rec_z));
					bad |= chk("rec_block", 32'(e.rec_block), 32'(rsp.rec_block));
					bad |= chk("rec_valid", 32'(e.rec_valid), 32'(rsp.rec_valid));
					bad |= chk("rec_last", 32'(e.rec_last), 32'(rsp.rec_last));
					bad |= chk("message_active", 32'(e.message_active),
						32'(rsp.message_active));
					bad |= chk("overflow_count", e.overflow_count, rsp.overflow_count);
					bad |= chk("edit_count", 32'(e.edit_count), 32'(rsp.edit_count));
				end
			end
			if (start && !busy) rsp_q.push_back(predict_rsp(req));
			if (bad) fail_count <= fail_count + 1;
			pending <= rsp_q.size();
		end
	end
endmodule

@@ dv/bucketed_sorted_edit_table_tb.sv @@
// Testbench top for the bucketed sorted edit table: drives requests and
// gives the verdict. Depends on bset_pkg, the block and its checker.
module bucketed_sorted_edit_table_tb;
	import bset_pkg::*;

	logic  clk, arst_n, start, busy, done;
	in_t   req;
	out_t  rsp;
	int    fail_count, pending;
	int    idle_cycles;
	bit    calm;

	bucketed_sorted_edit_table i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	bucketed_sorted_edit_table_chk i_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Watchdog: cycles with no request taken and no response
	always @(posedge clk) begin
		if (done || (start && !busy)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 40000) begin
			$display("bucketed_sorted_edit_table verification failed");
			$finish;
		end
	end

	// Issue one request and wait until it is taken; start stays high after
	task automatic send(in_t r);
		if (!calm) while ($urandom_range(99) < 16) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic in_t mk(op_t op, int x, int y, int z, int nb, int cur);
		in_t r;
		r = '0;
		r.op = op;
		r.pos_x = 16'(x);
		r.pos_y = 16'(y);
		r.pos_z = 16'(z);
		r.new_block = 8'(nb);
		r.current_block = 8'(cur);
		r.new_valid = 1'b1;
		r.column_ready = 1'b1;
		r.column_resident = 1'b1;
		return r;
	endfunction

	// Random request, mostly well formed within a few columns
	function automatic in_t rand_req();
		in_t r;
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		r = raw[$bits(in_t)-1:0];
		if ($urandom_range(9) < 8) begin
			r.op = ($urandom_range(9) < 6) ? OP_SET : op_t'(2'($urandom_range(3)));
			r.pos_x = 16'($urandom_range(47));
			r.pos_y = 16'($urandom_range(127));
			r.pos_z = 16'($urandom_range(31));
			r.new_block = 8'($urandom_range(3));
			r.current_block = 8'($urandom_range(3));
			r.new_valid = 1'b1;
			r.column_ready = 1'b1;
			r.column_resident = 1'b1;
			if (r.op == OP_REPLAY) begin
				r.pos_x = 16'($urandom_range(2));
				r.pos_z = 16'($urandom_range(1));
				r.entry_index = 10'($urandom_range(8));
			end
		end
		return r;
	endfunction

	initial begin
		in_t r;
		arst_n = 0;
		start = 0;
		req = '0;
		calm = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: extremes, every op, special cases
		send(mk(OP_REPLAY, 0, 0, 0, 0, 0));
		send(mk(OP_SET, 5, 10, 7, 3, 1));
		send(mk(OP_SET, 5, 10, 7, 4, 1));
		send(mk(OP_SET, 5, 11, 7, 9, 2));
		send(mk(OP_SET, 5, 9, 7, 9, 2));
		send(mk(OP_REPLAY, 0, 0, 0, 0, 0));
		r = mk(OP_REPLAY, 0, 0, 0, 0, 0); r.entry_index = 10'd2; send(r);
		r.entry_index = 10'd3; send(r);
		r.entry_index = 10'h3ff; send(r);
		r.column_resident = 1'b0; r.entry_index = 10'd0; send(r);
		send(mk(OP_REPLAY, 16, 0, 0, 0, 0));
		send(mk(OP_REPLAY, -1, 0, -1, 0, 0));
		send(mk(OP_SET, 5, 10, 7, 1, 1));
		send(mk(OP_SET, 255, 127, 255, 8, 0));
		send(mk(OP_SET, 256, 3, 3, 8, 0));
		send(mk(OP_SET, -32768, 3, 32767, 8, 0));
		send(mk(OP_SET, 3, -1, 3, 8, 0));
		send(mk(OP_SET, 3, 128, 3, 8, 0));
		send(mk(OP_SET, 3, 3, 3, 8, 8));
		r = mk(OP_SET, 3, 3, 3, 255, 0); r.new_valid = 1'b0; send(r);
		r = mk(OP_PROBE, 3, 3, 3, 0, 0); r.column_ready = 1'b0; send(r);
		send(mk(OP_PROBE, 3, 3, 3, 0, 0));
		send(mk(OP_TICK, 0, 0, 0, 0, 0));
		// Hold off until all responses are in
		start <= 0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		for (int i = 0; i < 265; i++) begin
			if (i == 100) calm = 1;
			if (i == 160) calm = 0;
			send(rand_req());
		end
		start <= 0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("bucketed_sorted_edit_table verification clean");
		else
			$display("bucketed_sorted_edit_table verification failed");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/core/bset_pkg.sv
rtl/core/bset_ctrl.sv
rtl/core/bset_dpath.sv
rtl/core/bucketed_sorted_edit_table.sv
dv/bucketed_sorted_edit_table_chk.sv
dv/bucketed_sorted_edit_table_tb.sv
